// ----- design/swm_pkg.sv -----
// Shared constants for the sliding window maximum filter.
`default_nettype none

package swm_pkg;

  // Default build: deepest window and sample width.
  localparam int unsigned WINDOW_MAX_DEF = 64;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // Width of the window size register.
  localparam int unsigned CFG_WIDTH = 7;

  // Window size after reset.
  localparam logic [CFG_WIDTH-1:0] CFG_RESET = CFG_WIDTH'(1);

endpackage

`default_nettype wire

// ----- design/sliding_window_maximum.sv -----
// Top level of the sliding window maximum filter: cell chain, fill counter and output register.
//
// Usage
//   Input channel: sample_i and stream_start_i travel with in_valid_i; a beat is taken
//   at a clock edge where in_valid_i is high and in_stall_o is low. stream_start_i high
//   begins a new sequence with this sample.
//   Output channel: window_max_o travels with out_valid_o and is taken when out_stall_i
//   is low. One result per input beat once the sequence holds window_size samples,
//   none before that.
//   Configuration: cfg_we_i writes cfg_wdata_i into the window size register; write it
//   only while the block is idle. Zero acts as 1, values above WINDOW_MAX as WINDOW_MAX.
// Timing
//   An accepted beat has its result on the output in the next cycle. Throughput is 1 beat
//   per cycle unless a result waits under out_stall_i: every cell updates its run maximum
//   in the same cycle, and the output register compares the new sample with the selected cell.
// Reset
//   The fill count and the output valid clear, the window size returns to 1.
// Stall
//   While a result waits under out_stall_i, in_stall_o is high and the result holds;
//   once the result is taken a new beat may enter in that same cycle.
`default_nettype none

module sliding_window_maximum
  import swm_pkg::*;
#(
  parameter int unsigned WINDOW_MAX = WINDOW_MAX_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // configuration
  input  wire logic                         cfg_we_i,
  input  wire logic [CFG_WIDTH-1:0]         cfg_wdata_i,
  // input channel
  input  wire logic                         in_valid_i,
  output      logic                         in_stall_o,
  input  wire logic signed [DATA_WIDTH-1:0] sample_i,
  input  wire logic                         stream_start_i,
  // output channel
  output      logic                         out_valid_o,
  input  wire logic                         out_stall_i,
  output      logic signed [DATA_WIDTH-1:0] window_max_o
);

  localparam int unsigned KW   = $clog2(WINDOW_MAX + 1);
  localparam int unsigned IDXW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  localparam logic signed [DATA_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic [CFG_WIDTH-1:0] win_q;
  logic [KW-1:0]        fill_q;
  logic [KW-1:0]        fill_d;
  logic                 out_valid_q;
  logic                 out_valid_d;

  logic [KW-1:0]        k_eff;
  logic [KW-1:0]        fill_base;
  logic [KW:0]          fill_inc;
  logic                 emit;
  logic                 accept;
  logic [IDXW-1:0]      sel;

  // tap[j] holds the maximum of the last j samples; tap[0] is the neutral value.
  logic signed [DATA_WIDTH-1:0] tap [WINDOW_MAX];

  // Window size register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      win_q <= cfg_wdata_i;
    end
  end

  // Clamp the window size to 1..WINDOW_MAX.
  always_comb begin
    if (win_q == '0) begin
      k_eff = KW'(1);
    end else if (32'(win_q) > 32'(WINDOW_MAX)) begin
      k_eff = KW'(WINDOW_MAX);
    end else begin
      k_eff = KW'(win_q);
    end
  end

  // Handshake: hold the input while a result waits under stall.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  // Fill count saturates at the window size; emit once the window is full.
  always_comb begin
    fill_base = stream_start_i ? '0 : fill_q;
    fill_inc  = {1'b0, fill_base} + (KW+1)'(1);
    emit      = (fill_inc >= {1'b0, k_eff});
    fill_d    = emit ? k_eff : fill_inc[KW-1:0];
    sel       = IDXW'(k_eff - KW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (accept) begin
      fill_q <= fill_d;
    end
  end

  // Output valid: set by an emitting beat, drop when taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = emit;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Chain of cells: cell j keeps the maximum of the last j+1 samples.
  assign tap[0] = SAMPLE_MIN;

  for (genvar j = 0; j < WINDOW_MAX - 1; j++) begin : g_cell
    swm_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk_i    (clk_i),
      .en_i     (accept),
      .sample_i (sample_i),
      .up_i     (tap[j]),
      .max_o    (tap[j+1])
    );
  end

  // Output register: the new sample against the maximum of the previous k-1 samples.
  swm_cell #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_out (
    .clk_i    (clk_i),
    .en_i     (accept & emit),
    .sample_i (sample_i),
    .up_i     (tap[sel]),
    .max_o    (window_max_o)
  );

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ----- design/swm_cell.sv -----
// One cell of the running-maximum chain: holds the maximum of a run of recent samples.
`default_nettype none

module swm_cell
  import swm_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         en_i,
  input  wire logic signed [DATA_WIDTH-1:0] sample_i,
  input  wire logic signed [DATA_WIDTH-1:0] up_i,
  output      logic signed [DATA_WIDTH-1:0] max_o
);

  logic signed [DATA_WIDTH-1:0] max_q;
  logic signed [DATA_WIDTH-1:0] max_d;

  // Take the larger of the new sample and the neighbour's run maximum.
  always_comb begin
    max_d = (sample_i > up_i) ? sample_i : up_i;
  end

  // Advance on every accepted beat, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      max_q <= max_d;
    end
  end

  assign max_o = max_q;

endmodule

`default_nettype wire

// ----- design/swm_checker.sv -----
// Port-level checks for the sliding window maximum filter, bound to the top level.
`default_nettype none

module swm_checker
  import swm_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         cfg_we_i,
  input wire logic [CFG_WIDTH-1:0]         cfg_wdata_i,
  input wire logic                         in_valid_i,
  input wire logic                         in_stall_o,
  input wire logic signed [DATA_WIDTH-1:0] sample_i,
  input wire logic                         out_valid_o,
  input wire logic                         out_stall_i,
  input wire logic signed [DATA_WIDTH-1:0] window_max_o
);

  logic [CFG_WIDTH-1:0] win_q;
  logic                 unit_win;

  // Track the window size as written on the port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      win_q <= cfg_wdata_i;
    end
  end

  assign unit_win = (win_q == CFG_WIDTH'(0)) || (win_q == CFG_WIDTH'(1));

  // A waiting result stays offered.
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("result dropped while stalled");

  // A waiting result keeps its value.
  a_out_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(window_max_o))
    else $error("result changed while stalled");

  // The input is held back only by a waiting result.
  a_in_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled with no waiting result");

  // With a one-sample window every beat returns its own sample next cycle.
  a_unit_window : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && unit_win) |=>
      (out_valid_o && (window_max_o == $past(sample_i))))
    else $error("one-sample window did not echo the sample");

endmodule

bind sliding_window_maximum swm_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_swm_checker (.*);

`default_nettype wire
